@@ hdl/spc_pkg.sv @@
// Shared types, constants and helpers for the scan point clustering core.
`default_nettype none

package spc_pkg;

    localparam int COORD_W      = 12;
    localparam int JOIN_W       = 13;
    localparam int SUM_W        = 24;
    localparam int COUNT_W      = 12;
    localparam int INDEX_W      = 5;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 48;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int MAX_POINTS_DEF  = 2048;

    localparam logic [JOIN_W-1:0]  JOIN_DIST_RESET = 13'd450;
    localparam logic [INDEX_W-1:0] INDEX_CEILING   = 5'd16;

    // close queue, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS  = COORD_W;
    localparam int DSTEP_W    = $clog2(DIV_STEPS);
    localparam logic [DSTEP_W-1:0] DIV_LAST_STEP = DSTEP_W'(DIV_STEPS - 1);

    // one closed object waiting for its centroid
    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] index;
        logic               kept;
        logic               sweep_end;
    } close_rec_t;

    // front to queue: up to two records per transfer
    typedef struct packed {
        logic [1:0] num;
        close_rec_t rec0;
        close_rec_t rec1;
    } queue_push_t;

    // queue status seen by front and back
    typedef struct packed {
        logic room_two;
        logic not_empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

    function automatic logic [INDEX_W-1:0] sat_inc(input logic [INDEX_W-1:0] idx);
        sat_inc = (idx < INDEX_CEILING) ? idx + INDEX_W'(1) : idx;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spc_front.sv @@
// Front end: point intake, leader clustering and close record generation.
`default_nettype none

module spc_front
    import spc_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int MAX_POINTS  = MAX_POINTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pt_valid,
    output logic                     pt_ready,
    input  wire logic [COORD_W-1:0]  pt_x,
    input  wire logic [COORD_W-1:0]  pt_y,
    input  wire logic                pt_last,
    input  wire logic                cfg_we,
    input  wire logic [JOIN_W-1:0]   cfg_wdata,
    input  wire queue_stat_t         q_stat,
    output queue_push_t              q_push
);

    logic [JOIN_W-1:0]  join_dist_reg;
    logic [COORD_W-1:0] anchor_x_reg, anchor_x_next;
    logic [COORD_W-1:0] anchor_y_reg, anchor_y_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0] points_reg, points_next;
    logic [INDEX_W-1:0] closed_reg, closed_next;
    logic               open_reg, open_next;

    logic               accept;
    logic [COORD_W-1:0] dx, dy;
    logic [JOIN_W-1:0]  manh_dist;
    logic               far;
    logic [INDEX_W-1:0] idx_after;
    close_rec_t         rec_old, rec_new;

    assign pt_ready = q_stat.room_two;
    assign accept   = pt_valid && pt_ready;

    always_comb begin
        dx        = (pt_x >= anchor_x_reg) ? pt_x - anchor_x_reg : anchor_x_reg - pt_x;
        dy        = (pt_y >= anchor_y_reg) ? pt_y - anchor_y_reg : anchor_y_reg - pt_y;
        manh_dist = {1'b0, dx} + {1'b0, dy};
        far       = open_reg && (manh_dist > join_dist_reg);

        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        points_next   = points_reg;
        closed_next   = closed_reg;
        open_next     = open_reg;

        if (accept) begin
            if (!open_reg || far) begin
                anchor_x_next = pt_x;
                anchor_y_next = pt_y;
                sum_x_next    = SUM_W'(pt_x);
                sum_y_next    = SUM_W'(pt_y);
                points_next   = COUNT_W'(1);
                open_next     = 1'b1;
            end else if (points_reg < COUNT_W'(MAX_POINTS)) begin
                sum_x_next  = sum_x_reg + SUM_W'(pt_x);
                sum_y_next  = sum_y_reg + SUM_W'(pt_y);
                points_next = points_reg + COUNT_W'(1);
            end
            if (far) begin
                closed_next = sat_inc(closed_reg);
            end
            if (pt_last) begin
                open_next   = 1'b0;
                closed_next = '0;
            end
        end

        idx_after = far ? sat_inc(closed_reg) : closed_reg;

        // object closed by a far point
        rec_old.sum_x     = sum_x_reg;
        rec_old.sum_y     = sum_y_reg;
        rec_old.count     = points_reg;
        rec_old.index     = closed_reg;
        rec_old.kept      = closed_reg < INDEX_W'(MAX_OBJECTS - 1);
        rec_old.sweep_end = 1'b0;

        // object closed by the last point
        rec_new.sum_x     = sum_x_next;
        rec_new.sum_y     = sum_y_next;
        rec_new.count     = points_next;
        rec_new.index     = idx_after;
        rec_new.kept      = idx_after < INDEX_W'(MAX_OBJECTS - 1);
        rec_new.sweep_end = 1'b1;

        q_push.num  = accept ? {1'b0, far} + {1'b0, pt_last} : 2'd0;
        q_push.rec0 = far ? rec_old : rec_new;
        q_push.rec1 = rec_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            join_dist_reg <= JOIN_DIST_RESET;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            points_reg    <= '0;
            closed_reg    <= '0;
            open_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                join_dist_reg <= cfg_wdata;
            end
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            points_reg   <= points_next;
            closed_reg   <= closed_next;
            open_reg     <= open_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/spc_close_queue.sv @@
// Close record queue between front and back, two writes and one read per cycle.
`default_nettype none

module spc_close_queue
    import spc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire queue_push_t q_push,
    input  wire logic        pop,
    output close_rec_t       head_rec,
    output queue_stat_t      q_stat
);

    close_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QPTR_W-1:0]   wr_ptr_p1;
    logic                do_pop;

    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);
    assign do_pop    = pop && (cnt_reg != '0);
    assign head_rec  = entry_reg[rd_ptr_reg];

    assign q_stat.room_two  = cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign q_stat.not_empty = cnt_reg != '0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(q_push.num);
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(q_push.num) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (q_push.num != 2'd0) begin
            entry_reg[wr_ptr_reg] <= q_push.rec0;
        end
        if (q_push.num == 2'd2) begin
            entry_reg[wr_ptr_p1] <= q_push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push.num != 2'd0) |-> (cnt_reg + QCNT_W'(q_push.num) <= QCNT_W'(QUEUE_DEPTH)))
        else $error("close queue overflow");

    a_fill_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("close queue pointers disagree with fill count");

endmodule

`default_nettype wire

@@ hdl/spc_back.sv @@
// Back end: centroid division, one quotient bit per cycle, and result register.
`default_nettype none

module spc_back
    import spc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire queue_stat_t        q_stat,
    input  wire close_rec_t         head_rec,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [COORD_W-1:0]      res_cx,
    output logic [COORD_W-1:0]      res_cy,
    output logic [COUNT_W-1:0]      res_count,
    output logic [INDEX_W-1:0]      res_index,
    output logic                    res_kept,
    output logic                    res_end
);

    back_state_t          state_reg, state_next;
    logic [DSTEP_W-1:0]   step_reg, step_next;
    logic [COORD_W-1:0]   rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [COORD_W-1:0]   quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic [COUNT_W-1:0]   div_reg, div_next;
    close_rec_t           rec_reg, rec_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_cx_reg, out_cx_next, out_cy_reg, out_cy_next;
    close_rec_t           out_rec_reg, out_rec_next;

    logic [COORD_W:0]     tx, ty;
    logic                 ge_x, ge_y;
    logic                 out_free;

    assign out_free = !out_valid_reg || res_ready;

    always_comb begin
        // remainder stays below the divisor since the mean fits 12 bits
        tx   = {rem_x_reg, quo_x_reg[COORD_W-1]};
        ty   = {rem_y_reg, quo_y_reg[COORD_W-1]};
        ge_x = tx >= {1'b0, div_reg};
        ge_y = ty >= {1'b0, div_reg};

        state_next     = state_reg;
        step_next      = step_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        quo_x_next     = quo_x_reg;
        quo_y_next     = quo_y_reg;
        div_next       = div_reg;
        rec_next       = rec_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_cx_next    = out_cx_reg;
        out_cy_next    = out_cy_reg;
        out_rec_next   = out_rec_reg;
        pop            = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (q_stat.not_empty) begin
                    pop        = 1'b1;
                    rec_next   = head_rec;
                    rem_x_next = head_rec.sum_x[SUM_W-1:COORD_W];
                    quo_x_next = head_rec.sum_x[COORD_W-1:0];
                    rem_y_next = head_rec.sum_y[SUM_W-1:COORD_W];
                    quo_y_next = head_rec.sum_y[COORD_W-1:0];
                    div_next   = head_rec.count;
                    step_next  = '0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                rem_x_next = ge_x ? COORD_W'(tx - {1'b0, div_reg}) : tx[COORD_W-1:0];
                rem_y_next = ge_y ? COORD_W'(ty - {1'b0, div_reg}) : ty[COORD_W-1:0];
                quo_x_next = {quo_x_reg[COORD_W-2:0], ge_x};
                quo_y_next = {quo_y_reg[COORD_W-2:0], ge_y};
                step_next  = step_reg + DSTEP_W'(1);
                if (step_reg == DIV_LAST_STEP) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cx_next    = quo_x_reg;
                    out_cy_next    = quo_y_reg;
                    out_rec_next   = rec_reg;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        quo_x_reg   <= quo_x_next;
        quo_y_reg   <= quo_y_next;
        div_reg     <= div_next;
        rec_reg     <= rec_next;
        out_cx_reg  <= out_cx_next;
        out_cy_reg  <= out_cy_next;
        out_rec_reg <= out_rec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_cx    = out_cx_reg;
    assign res_cy    = out_cy_reg;
    assign res_count = out_rec_reg.count;
    assign res_index = out_rec_reg.index;
    assign res_kept  = out_rec_reg.kept;
    assign res_end   = out_rec_reg.sweep_end;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == BK_IDLE && q_stat.not_empty))
        else $error("queue popped outside idle or while empty");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE && $past(state_reg) == BK_DIV) |-> 1'b0)
        else $error("division left without delivering a result");

endmodule

`default_nettype wire

@@ hdl/scan_point_clustering_core.sv @@
// Top level of the scan point clustering core: front, close queue and back.
// Flow: the object a point closes leaves the back end after its record is popped: a load,
//   12 divider steps, then an output load that waits while the output register is full.
// Throughput: one point per cycle while the close queue has room for two records;
//   each closed object holds the shared x/y divider until its output load.
// Reset: aresetn is synchronous, active low; join_distance returns to 450, no object
//   is open, the object counter, queue and output register are empty.
`default_nettype none

module scan_point_clustering_core
    import spc_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,  // objects flagged kept: MAX_OBJECTS-1
    parameter int MAX_POINTS  = MAX_POINTS_DEF    // member count limit per object
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // point input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] point_x, [23:12] point_y
    input  wire logic                  s_tlast,   // last_point
    // join_distance register write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [JOIN_W-1:0]     cfg_data,
    // object results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [11:0] centroid_x, [23:12] centroid_y,
                                                  // [35:24] member_count,
                                                  // [40:36] object_index, [47:41] zero
    output logic                       m_tuser,   // kept
    output logic                       m_tlast    // sweep_end
);

    queue_push_t        q_push;
    queue_stat_t        q_stat;
    close_rec_t         head_rec;
    logic               pop;
    logic [COORD_W-1:0] res_cx, res_cy;
    logic [COUNT_W-1:0] res_count;
    logic [INDEX_W-1:0] res_index;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // front: distance to anchor, join or close, emits up to two close records per point
    spc_front #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pt_valid  (s_tvalid),
        .pt_ready  (s_tready),
        .pt_x      (s_tdata[COORD_W-1:0]),
        .pt_y      (s_tdata[2*COORD_W-1:COORD_W]),
        .pt_last   (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    // decouples point intake from the slow centroid division
    spc_close_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    // back: sums / count for x and y side by side, then output register
    spc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .head_rec  (head_rec),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_cx    (res_cx),
        .res_cy    (res_cy),
        .res_count (res_count),
        .res_index (res_index),
        .res_kept  (m_tuser),
        .res_end   (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W - 2*COORD_W - COUNT_W - INDEX_W)'(0),
                      res_index, res_count, res_cy, res_cx};

endmodule

`default_nettype wire

@@ tb/sv/scan_point_clustering_core_tb.sv @@
// Self-checking testbench for the scan point clustering core.
`default_nettype none

module scan_point_clustering_core_tb
    import spc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_BOUND   = 20_000;
    localparam int SETTLE_CYCLES = 40;      // well beyond the close latency
    localparam int RANDOM_ITEMS  = 1050;
    localparam int QUIET_TAIL    = 150;     // last random transfers run without idling
    localparam int PRINT_CAP     = 40;

    // one closed object as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COUNT_W-1:0] members;
        logic [INDEX_W-1:0] index;
        logic               kept;
        logic               sweep_end;
    } centroid_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;    // [11:0] point_x, [23:12] point_y
    logic                  s_tlast   = 1'b0;  // last_point
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [JOIN_W-1:0]     cfg_data  = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [11:0] centroid_x, [23:12] centroid_y,
                                              // [35:24] member_count, [40:36] object_index,
                                              // [47:41] zero
    logic                  m_tuser;           // kept
    logic                  m_tlast;           // sweep_end

    scan_point_clustering_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Clustering predictor: own copy of the register and object state
    // ------------------------------------------------------------------
    logic [JOIN_W-1:0]  join_dist   = JOIN_DIST_RESET;
    logic [COORD_W-1:0] anchor_x    = '0;
    logic [COORD_W-1:0] anchor_y    = '0;
    logic [SUM_W-1:0]   sum_x       = '0;
    logic [SUM_W-1:0]   sum_y       = '0;
    logic [COUNT_W-1:0] member_cnt  = '0;
    logic [INDEX_W-1:0] closed_cnt  = '0;
    bit                 obj_open    = 1'b0;

    centroid_t pending_objects[$];   // centroids still owed by the block

    int  error_count   = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  long_hold_len = 0;          // request for one long m_tready hold-off
    bit  quiet_tail    = 1'b0;       // no idling on either side
    bit  input_offered = 1'b0;       // s_tvalid currently high

    function automatic void open_object(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y);
        anchor_x   = x;
        anchor_y   = y;
        sum_x      = SUM_W'(x);
        sum_y      = SUM_W'(y);
        member_cnt = COUNT_W'(1);
        obj_open   = 1'b1;
    endfunction

    function automatic void close_object(input bit final_one);
        centroid_t c;
        c.cx        = COORD_W'(sum_x / member_cnt);
        c.cy        = COORD_W'(sum_y / member_cnt);
        c.members   = member_cnt;
        c.index     = closed_cnt;
        c.kept      = (closed_cnt < INDEX_W'(MAX_OBJECTS_DEF - 1));
        c.sweep_end = final_one;
        pending_objects.push_back(c);
        if (closed_cnt < INDEX_CEILING)
            closed_cnt = closed_cnt + INDEX_W'(1);
        obj_open = 1'b0;
    endfunction

    function automatic void cluster_point(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input bit last);
        int dx;
        int dy;
        if (!obj_open) begin
            open_object(x, y);
        end else begin
            dx = int'(x) - int'(anchor_x);
            dy = int'(y) - int'(anchor_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx + dy <= int'(join_dist)) begin
                // a full object drops the point but still honors its last mark
                if (int'(member_cnt) < MAX_POINTS_DEF) begin
                    sum_x      = sum_x + SUM_W'(x);
                    sum_y      = sum_y + SUM_W'(y);
                    member_cnt = member_cnt + COUNT_W'(1);
                end
            end else begin
                close_object(1'b0);
                open_object(x, y);
            end
        end
        if (last) begin
            close_object(1'b1);
            closed_cnt = '0;
        end
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > 4095) return COORD_W'(4095);
        return COORD_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // sampled at the edge, before the block's own updates land
    always @(posedge aclk) begin : result_check
        centroid_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_objects.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = pending_objects.pop_front();
                if (m_tdata[11:0] !== want.cx)
                    report_mismatch("centroid_x", m_tdata[11:0], want.cx);
                if (m_tdata[23:12] !== want.cy)
                    report_mismatch("centroid_y", m_tdata[23:12], want.cy);
                if (m_tdata[35:24] !== want.members)
                    report_mismatch("member_count", m_tdata[35:24], want.members);
                if (m_tdata[40:36] !== want.index)
                    report_mismatch("object_index", m_tdata[40:36], want.index);
                if (m_tdata[47:41] !== 7'd0)
                    report_mismatch("tdata padding", m_tdata[47:41], 0);
                if (m_tuser !== want.kept)
                    report_mismatch("kept", m_tuser, want.kept);
                if (m_tlast !== want.sweep_end)
                    report_mismatch("sweep_end", m_tlast, want.sweep_end);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random hold-off bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_ready_driver
        int n;
        @(posedge aclk);
        forever begin
            if (long_hold_len != 0) begin
                m_tready <= 1'b0;
                repeat (long_hold_len) @(posedge aclk);
                long_hold_len = 0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one point; s_tvalid stays high afterwards so back-to-back
    // transfers never lower and raise it within one step.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input bit last);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            if (input_offered)
                s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {y, x};
        s_tlast       <= last;
        input_offered  = 1'b1;
        do @(posedge aclk); while (!s_tready);
        cluster_point(x, y, last);
        items_sent++;
    endtask

    task automatic release_input();
        if (input_offered) begin
            s_tvalid     <= 1'b0;
            input_offered = 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_results(input int bound);
        int waited;
        waited = 0;
        while (pending_objects.size() != 0 && waited < bound) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // register writes only while idle: all results back, pipeline settled
    task automatic set_join_distance(input logic [JOIN_W-1:0] value);
        release_input();
        wait_results(DRAIN_BOUND);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        join_dist  = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset value 450: single-point sweep, field extremes, boundary at 450/451,
    // far point together with last, truncating mean.
    task automatic test_reset_value_sweeps();
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd3870, 12'd3870, 1'b0);       // exactly 450 away
        send_point(12'd0, 12'd0, 1'b1);             // far and last: two results
        send_point(12'd1000, 12'd1000, 1'b0);
        send_point(12'd1001, 12'd1000, 1'b0);
        send_point(12'd1001, 12'd1001, 1'b0);
        send_point(12'd1000, 12'd1451, 1'b0);       // 451 away: closes
        send_point(12'd1300, 12'd1451, 1'b0);
        send_point(12'd2000, 12'd0, 1'b1);
    endtask

    task automatic test_join_extremes();
        set_join_distance(13'd0);
        send_point(12'd5, 12'd7, 1'b0);
        send_point(12'd5, 12'd7, 1'b0);             // zero distance joins
        send_point(12'd5, 12'd8, 1'b0);
        send_point(12'd5, 12'd8, 1'b1);
        set_join_distance(13'd8191);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd0, 12'd4095, 1'b1);
        set_join_distance(13'd8190);
        send_point(12'd4095, 12'd0, 1'b0);
        send_point(12'd0, 12'd4095, 1'b1);          // 8190: largest possible distance
    endtask

    // more objects than the index can count: saturation and kept flag
    task automatic test_many_objects();
        set_join_distance(13'd0);
        for (int i = 0; i < 20; i++)
            send_point(COORD_W'(i * 200), COORD_W'(4095 - i * 200), i == 19);
        send_point(12'd77, 12'd33, 1'b1);           // new sweep restarts the index
    endtask

    // write between points of an open sweep; applies from the next point
    task automatic test_midsweep_write();
        set_join_distance(13'd100);
        send_point(12'd2000, 12'd2000, 1'b0);
        send_point(12'd2050, 12'd2040, 1'b0);
        set_join_distance(13'd4000);
        send_point(12'd3000, 12'd3000, 1'b0);
        send_point(12'd0, 12'd0, 1'b1);             // exactly 4000 away
    endtask

    // one object past the member limit; extra points are dropped
    task automatic test_object_full();
        set_join_distance(13'd8191);
        for (int i = 0; i < MAX_POINTS_DEF + 3; i++)
            send_point(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                       1'b0);
        send_point(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)), 1'b1);
    endtask

    // long receiver hold-off while every point closes an object
    task automatic test_output_backpressure();
        set_join_distance(13'd0);
        long_hold_len = 400;
        for (int i = 0; i < 60; i++)
            send_point(i[0] ? 12'd4095 : 12'd0, i[0] ? 12'd0 : 12'd4095, i == 59);
    endtask

    // random sweeps: clustered points with random content, some noise
    task automatic test_random_sweeps();
        int target;
        int len;
        int radius;
        int pick;
        int center_x;
        int center_y;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            // no register writes in the tail, they would pause the input
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       set_join_distance(13'd0);
                    1:       set_join_distance(13'd1);
                    2:       set_join_distance(13'd8191);
                    3:       set_join_distance(JOIN_W'($urandom_range(0, 8191)));
                    default: set_join_distance(JOIN_W'($urandom_range(20, 600)));
                endcase
            end
            len      = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 30);
            radius   = (join_dist > 800) ? 400 : int'(join_dist) / 2;
            center_x = $urandom_range(0, 4095);
            center_y = $urandom_range(0, 4095);
            for (int i = 0; i < len; i++) begin
                if (target - items_sent <= QUIET_TAIL)
                    quiet_tail = 1'b1;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    px = clamp_coord(center_x + $urandom_range(0, 2 * radius) - radius);
                    py = clamp_coord(center_y + $urandom_range(0, 2 * radius) - radius);
                end else if (pick < 9) begin
                    // move on to a new object
                    center_x = $urandom_range(0, 4095);
                    center_y = $urandom_range(0, 4095);
                    px = COORD_W'(center_x);
                    py = COORD_W'(center_y);
                end else begin
                    px = COORD_W'($urandom_range(0, 4095));
                    py = COORD_W'($urandom_range(0, 4095));
                end
                send_point(px, py, i == len - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_value_sweeps();
        test_join_extremes();
        test_many_objects();
        test_midsweep_write();
        test_object_full();
        test_output_backpressure();
        test_random_sweeps();

        release_input();
        wait_results(DRAIN_BOUND);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_objects.size() != 0)
            report_mismatch("results left outstanding", pending_objects.size(), 0);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
